/* hdl/i2p_pkg.sv */
package i2p_pkg;

	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_MUL   = 8'h2A;
	localparam logic [7:0] CH_ADD   = 8'h2B;
	localparam logic [7:0] CH_SUB   = 8'h2D;
	localparam logic [7:0] CH_DIV   = 8'h2F;

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_OVERFLOW = 2'd1;
	localparam logic [1:0] ERR_CLOSE    = 2'd2;
	localparam logic [1:0] ERR_OPEN     = 2'd3;

	localparam logic [1:0] PREC_NONE = 2'd0;
	localparam logic [1:0] PREC_ADD  = 2'd1;
	localparam logic [1:0] PREC_MUL  = 2'd2;

	typedef enum logic [2:0] {
		K_NONE,
		K_OPND,
		K_OPEN,
		K_CLOSE,
		K_OPER
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  ch;
		logic [1:0]  prec;
		logic        last;
	} tok_t;

	function automatic logic [1:0] prec_of(input logic [7:0] c);
		logic [1:0] p;
		p = PREC_NONE;
		if (c == CH_ADD || c == CH_SUB) begin
			p = PREC_ADD;
		end else if (c == CH_MUL || c == CH_DIV) begin
			p = PREC_MUL;
		end
		return p;
	endfunction

endpackage

/* hdl/infix_to_postfix_converter.sv */
// Channel  Signals                                          Accepted when
// item     item_valid, item_stall, ch, last_char            item_valid && !item_stall
// result   result_valid, result_stall, out_char,            result_valid && !result_stall
//          char_valid, end_of_expr, error
//
// An operand passes through the front-end register, the two-entry queue and the result
// register of the back end; an ignored character is dropped by the front end unless it
// is the last one. An operator or a ')' is first classified; each operator popped then
// waits for the registered read of the stack memory, and the final compare or the pop of
// the matching '(' ends it. After the final character the stack is flushed entry by
// entry, and an end-marked transaction closes the expression.
// Reset is asynchronous and clears the stack count, error code and all valids;
// the stack memory itself is never cleared. A held result does not stop
// the front end, which keeps taking characters until its output register and the
// two-entry queue behind it are full.
module infix_to_postfix_converter #(
	parameter int STACK_DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic [7:0] ch,
	input  logic       last_char,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [7:0] out_char,
	output logic       char_valid,
	output logic       end_of_expr,
	output logic [1:0] error
);
	import i2p_pkg::*;

	logic fr_valid;
	logic q_full;
	tok_t fr_tok;
	logic q_valid;
	logic q_pop;
	tok_t q_tok;

	i2p_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.ch         (ch),
		.last_char  (last_char),
		.tok_valid  (fr_valid),
		.tok_full   (q_full),
		.tok        (fr_tok)
	);

	i2p_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fr_valid),
		.full     (q_full),
		.wr_tok   (fr_tok),
		.rd_valid (q_valid),
		.rd_pop   (q_pop),
		.rd_tok   (q_tok)
	);

	i2p_back #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.tok_valid    (q_valid),
		.tok          (q_tok),
		.tok_pop      (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.out_char     (out_char),
		.char_valid   (char_valid),
		.end_of_expr  (end_of_expr),
		.error        (error)
	);

endmodule

/* hdl/i2p_front.sv */
module i2p_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_stall,
	input  logic [7:0]    ch,
	input  logic          last_char,
	output logic          tok_valid,
	input  logic          tok_full,
	output i2p_pkg::tok_t tok
);
	import i2p_pkg::*;

	tok_t  cls;
	logic  keep;
	logic  accept;
	logic  v_s1;
	tok_t  tok_s1;

	always_comb begin
		cls.ch   = ch;
		cls.last = last_char;
		cls.prec = prec_of(ch);
		if ((ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h61 && ch <= 8'h7A) ||
				(ch >= 8'h41 && ch <= 8'h5A)) begin
			cls.kind = K_OPND;
		end else if (ch == CH_OPEN) begin
			cls.kind = K_OPEN;
		end else if (ch == CH_CLOSE) begin
			cls.kind = K_CLOSE;
		end else if (cls.prec != PREC_NONE) begin
			cls.kind = K_OPER;
		end else begin
			cls.kind = K_NONE;
		end
	end

	// Ignored characters are dropped here unless they close the expression.
	assign keep       = (cls.kind != K_NONE) || last_char;
	assign item_stall = v_s1 && tok_full;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept && keep) begin
			v_s1 <= 1'b1;
		end else if (!tok_full) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && keep) begin
			tok_s1 <= cls;
		end
	end

	assign tok_valid = v_s1;
	assign tok       = tok_s1;

endmodule

/* hdl/i2p_queue.sv */
module i2p_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          full,
	input  i2p_pkg::tok_t wr_tok,
	output logic          rd_valid,
	input  logic          rd_pop,
	output i2p_pkg::tok_t rd_tok
);
	import i2p_pkg::*;

	tok_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign full     = (cnt_q == 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign push     = wr_valid && !full;
	assign pop      = rd_pop && rd_valid;
	assign rd_tok   = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= wr_tok;
		end
	end

endmodule

/* hdl/i2p_back.sv */
module i2p_back #(
	parameter int STACK_DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          tok_valid,
	input  i2p_pkg::tok_t tok,
	output logic          tok_pop,
	output logic          result_valid,
	input  logic          result_stall,
	output logic [7:0]    out_char,
	output logic          char_valid,
	output logic          end_of_expr,
	output logic [1:0]    error
);
	import i2p_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CLOSE = 2'd1;
	localparam logic [1:0] ST_OPER  = 2'd2;
	localparam logic [1:0] ST_FLUSH = 2'd3;

	logic [7:0]    stk_mem [STACK_DEPTH];
	logic [7:0]    rd_q;
	logic          rd_ok_q;
	logic [CW-1:0] cnt_q;
	logic [1:0]    err_q;
	logic [1:0]    state_q;
	logic [1:0]    state_nxt;

	logic          pend_v_q;
	logic [7:0]    pend_char_q;
	logic [1:0]    pend_err_q;

	logic          res_v_q;
	logic [7:0]    res_char_q;
	logic          res_cv_q;
	logic          res_end_q;
	logic [1:0]    res_err_q;

	logic          out_free;
	logic          stk_empty;
	logic          stk_full;
	logic          top_open;
	logic          push_try;
	logic          push;
	logic          pop;
	logic          emit;
	logic [7:0]    emit_char;
	logic          fin;
	logic          done_main;
	logic          note;
	logic [1:0]    note_code;
	logic          res_load;
	logic [AW-1:0] top_idx;
	logic [AW-1:0] wr_idx;

	assign out_free  = !res_v_q || !result_stall;
	assign stk_empty = (cnt_q == '0);
	assign stk_full  = (cnt_q == CW'(STACK_DEPTH));
	assign top_open  = (rd_q == CH_OPEN);
	assign top_idx   = AW'(cnt_q - CW'(1));
	assign wr_idx    = cnt_q[AW-1:0];
	assign push      = push_try && !stk_full;

	always_comb begin
		state_nxt = state_q;
		push_try  = 1'b0;
		pop       = 1'b0;
		emit      = 1'b0;
		emit_char = rd_q;
		fin       = 1'b0;
		done_main = 1'b0;
		note      = 1'b0;
		note_code = ERR_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (tok_valid) begin
					unique case (tok.kind)
						K_OPND: begin
							if (out_free) begin
								emit      = 1'b1;
								emit_char = tok.ch;
								done_main = 1'b1;
							end
						end
						K_OPEN: begin
							push_try  = 1'b1;
							done_main = 1'b1;
						end
						K_CLOSE: state_nxt = ST_CLOSE;
						K_OPER:  state_nxt = ST_OPER;
						default: done_main = 1'b1;
					endcase
				end
			end
			ST_CLOSE: begin
				if (stk_empty) begin
					note      = 1'b1;
					note_code = ERR_CLOSE;
					done_main = 1'b1;
				end else if (rd_ok_q) begin
					if (top_open) begin
						pop       = 1'b1;
						done_main = 1'b1;
					end else if (out_free) begin
						emit = 1'b1;
						pop  = 1'b1;
					end
				end
			end
			ST_OPER: begin
				if (stk_empty) begin
					push_try  = 1'b1;
					done_main = 1'b1;
				end else if (rd_ok_q) begin
					if (top_open || prec_of(rd_q) < tok.prec) begin
						push_try  = 1'b1;
						done_main = 1'b1;
					end else if (out_free) begin
						emit = 1'b1;
						pop  = 1'b1;
					end
				end
			end
			ST_FLUSH: begin
				if (stk_empty) begin
					if (out_free) begin
						fin       = 1'b1;
						state_nxt = ST_IDLE;
					end
				end else if (rd_ok_q) begin
					if (top_open) begin
						pop       = 1'b1;
						note      = 1'b1;
						note_code = ERR_OPEN;
					end else if (out_free) begin
						emit = 1'b1;
						pop  = 1'b1;
					end
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
		if (push_try && stk_full) begin
			note      = 1'b1;
			note_code = ERR_OVERFLOW;
		end
		if (done_main) begin
			state_nxt = tok.last ? ST_FLUSH : ST_IDLE;
		end
	end

	// A transaction leaves the queue once its whole expression step is finished.
	assign tok_pop  = fin || (done_main && !tok.last);
	assign res_load = fin || (emit && (!tok.last || pend_v_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			err_q    <= ERR_NONE;
			rd_ok_q  <= 1'b0;
			pend_v_q <= 1'b0;
			res_v_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			rd_ok_q <= !(push || pop);
			if (push) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (fin) begin
				err_q <= ERR_NONE;
			end else if (note && err_q == ERR_NONE) begin
				err_q <= note_code;
			end
			if (fin) begin
				pend_v_q <= 1'b0;
			end else if (emit && tok.last) begin
				pend_v_q <= 1'b1;
			end
			if (res_load) begin
				res_v_q <= 1'b1;
			end else if (!result_stall) begin
				res_v_q <= 1'b0;
			end
		end
	end

	// In the last step each result is held back one place so that the final
	// one can still be given the end mark and the error code of the expression.
	always_ff @(posedge clk) begin
		if (emit && tok.last) begin
			pend_char_q <= emit_char;
			pend_err_q  <= err_q;
		end
		if (fin) begin
			res_char_q <= pend_v_q ? pend_char_q : 8'd0;
			res_cv_q   <= pend_v_q;
			res_end_q  <= 1'b1;
			res_err_q  <= err_q;
		end else if (res_load && tok.last) begin
			res_char_q <= pend_char_q;
			res_cv_q   <= 1'b1;
			res_end_q  <= 1'b0;
			res_err_q  <= pend_err_q;
		end else if (res_load) begin
			res_char_q <= emit_char;
			res_cv_q   <= 1'b1;
			res_end_q  <= 1'b0;
			res_err_q  <= err_q;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			stk_mem[wr_idx] <= tok.ch;
		end
		rd_q <= stk_mem[top_idx];
	end

	assign result_valid = res_v_q;
	assign out_char     = res_char_q;
	assign char_valid   = res_cv_q;
	assign end_of_expr  = res_end_q;
	assign error        = res_err_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_pop_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> rd_ok_q && !stk_empty)
		else $error("pop with stale top of stack");

	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !pend_v_q)
		else $error("held result left over between expressions");

	a_bare_marker: assert property (@(posedge clk) disable iff (!arst_n)
		res_v_q && !res_cv_q |-> res_end_q && res_char_q == 8'd0)
		else $error("bare result that is not an end marker");

	a_fin_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> err_q == ERR_NONE && stk_empty && res_v_q && res_end_q)
		else $error("expression end did not reset state");

endmodule
